FILE: rtl/emp_pkg.sv
package emp_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] RegMinPulse       = 2'd0;
	localparam logic [1:0] RegReportInterval = 2'd1;
	localparam logic [1:0] RegBeatsPerKwh    = 2'd2;
	localparam logic [1:0] RegAverageWindow  = 2'd3;

	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 16;

	// values after reset
	localparam logic [15:0] ResetMinPulseMs    = 16'd80;
	localparam logic [15:0] ResetReportInterval = 16'd80;
	localparam logic [15:0] ResetBeatsPerKwh   = 16'd800;
	localparam logic [7:0]  ResetAverageWindow = 8'd100;

	// shared divider
	localparam int DivDvdW = 32;
	localparam int DivDvsW = 16;

	typedef struct packed {
		logic               start;
		logic [DivDvdW-1:0] dividend;
		logic [DivDvsW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DivDvdW-1:0] quotient;
		logic [DivDvsW-1:0] remainder;
	} div_rsp_t;

endpackage

FILE: rtl/emp_div.sv
// Restoring divider, one quotient bit per cycle.
module emp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  emp_pkg::div_req_t req,
	output emp_pkg::div_rsp_t rsp
);

	localparam int StepW = $clog2(emp_pkg::DivDvdW);

	logic [emp_pkg::DivDvdW-1:0] dvd_q;
	logic [emp_pkg::DivDvsW-1:0] dvs_q;
	logic [emp_pkg::DivDvsW-1:0] rem_q;
	logic [StepW-1:0]            step_q;
	logic                        busy_q;
	logic                        done_q;

	logic [emp_pkg::DivDvsW:0]   shifted;
	logic [emp_pkg::DivDvsW+1:0] diff;
	logic                        q_bit;
	logic [emp_pkg::DivDvsW-1:0] next_rem;

	always_comb begin
		shifted  = {rem_q, dvd_q[emp_pkg::DivDvdW-1]};
		diff     = {1'b0, shifted} - {2'b00, dvs_q};
		q_bit    = ~diff[emp_pkg::DivDvsW+1];
		next_rem = q_bit ? diff[emp_pkg::DivDvsW-1:0] : shifted[emp_pkg::DivDvsW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == StepW'(emp_pkg::DivDvdW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[emp_pkg::DivDvdW-2:0], q_bit};
			rem_q <= next_rem;
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

FILE: rtl/energy_meter_pulse_counter_top.sv
// Energy meter pulse counter. Each request on the slave stream is one edge of the meter pulse
// line: its new level and a millisecond timestamp. A low edge marks the start of a pulse; a
// high edge after a nonzero start measures the pulse width, folds it into a running average
// and, if the width reaches min_pulse_ms, counts a beat, raising report_due on every
// report_interval-th beat, where the kWh total advances once beats_per_kwh beats have gathered.
// Every edge returns exactly one result. The block takes one edge at a time and drops tready
// while it works: a low edge or a high edge with no start goes straight to its result, a
// measured edge passes the measure, sum and average steps, and a counted beat with nonzero
// report_interval adds the report check. One restoring divider forms the average, then the
// beat count modulo report_interval. A finished result waits in the output register, so a new
// edge may be taken meanwhile. Configuration is written through cfg_we/cfg_index/cfg_data
// while the block is idle; the user must keep to this, as the block does not enforce it.
module energy_meter_pulse_counter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [emp_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [emp_pkg::CfgDataW-1:0]   cfg_data,
	// edge requests
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [39:0]                    s_tdata,  // line_level[0], now_ms[32:1], zeros
	// results
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// beat_counted[0], report_due[1], beat_total[33:2], kwh_total[65:34],
	// average_width_ms[97:66], zeros
	output logic [103:0]                   m_tdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MEAS,
		S_SUM,
		S_AVG,
		S_MOD,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] min_pulse_q;
	logic [15:0] report_interval_q;
	logic [15:0] beats_per_kwh_q;
	logic [7:0]  average_window_q;

	// block state
	logic [31:0] pulse_start_q;
	logic [31:0] width_sum_q;
	logic [7:0]  width_count_q;
	logic [31:0] average_q;
	logic [31:0] beat_count_q;
	logic [31:0] toward_kwh_q;
	logic [31:0] kwh_q;

	// per-request working registers
	logic [31:0] now_q;
	logic [31:0] width_q;
	logic        beat_q;
	logic        report_q;

	// output register
	logic         m_tvalid_q;
	logic [103:0] m_tdata_q;

	emp_pkg::div_req_t div_req;
	emp_pkg::div_rsp_t div_rsp;

	logic [31:0] sum_new;
	logic [8:0]  cnt_new;
	logic        window_full;
	logic        is_beat;
	logic        out_load;

	emp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		sum_new     = width_sum_q + width_q;
		cnt_new     = {1'b0, width_count_q} + 9'd1;
		window_full = cnt_new > {1'b0, average_window_q};
		is_beat     = width_q >= {16'h0000, min_pulse_q};
		// load the output register when a result is ready and the register is free
		out_load    = (state_q == S_DONE) && (!m_tvalid_q || m_tready);
	end

	// Drive the shared divider: the average in S_SUM, the report check on the way out of S_AVG.
	always_comb begin
		div_req = '0;
		if (state_q == S_SUM) begin
			div_req.start    = 1'b1;
			div_req.dividend = sum_new;
			div_req.divisor  = {7'd0, cnt_new};
		end else if (state_q == S_AVG && div_rsp.done && beat_q && report_interval_q != '0) begin
			div_req.start    = 1'b1;
			div_req.dividend = beat_count_q;
			div_req.divisor  = report_interval_q;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q       <= emp_pkg::ResetMinPulseMs;
			report_interval_q <= emp_pkg::ResetReportInterval;
			beats_per_kwh_q   <= emp_pkg::ResetBeatsPerKwh;
			average_window_q  <= emp_pkg::ResetAverageWindow;
		end else if (cfg_we) begin
			unique case (cfg_index)
				emp_pkg::RegMinPulse:       min_pulse_q       <= cfg_data;
				emp_pkg::RegReportInterval: report_interval_q <= cfg_data;
				emp_pkg::RegBeatsPerKwh:    beats_per_kwh_q   <= cfg_data;
				emp_pkg::RegAverageWindow:  average_window_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Sequencer with the block state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pulse_start_q <= '0;
			width_sum_q   <= '0;
			width_count_q <= '0;
			average_q     <= '0;
			beat_count_q  <= '0;
			toward_kwh_q  <= '0;
			kwh_q         <= '0;
			now_q         <= '0;
			width_q       <= '0;
			beat_q        <= 1'b0;
			report_q      <= 1'b0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						now_q    <= s_tdata[32:1];
						beat_q   <= 1'b0;
						report_q <= 1'b0;
						// a low edge records the start; a high edge with no start measures nothing
						if (!s_tdata[0]) begin
							pulse_start_q <= s_tdata[32:1];
							state_q       <= S_DONE;
						end else if (pulse_start_q == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MEAS;
						end
					end
				end
				S_MEAS: begin
					width_q <= now_q - pulse_start_q;
					state_q <= S_SUM;
				end
				S_SUM: begin
					// divider takes sum_new / cnt_new this cycle; clear the window once the count exceeds average_window
					if (window_full) begin
						width_sum_q   <= '0;
						width_count_q <= '0;
					end else begin
						width_sum_q   <= sum_new;
						width_count_q <= cnt_new[7:0];
					end
					if (is_beat) begin
						beat_q       <= 1'b1;
						beat_count_q <= beat_count_q + 32'd1;
						toward_kwh_q <= toward_kwh_q + 32'd1;
					end
					state_q <= S_AVG;
				end
				S_AVG: begin
					if (div_rsp.done) begin
						average_q <= div_rsp.quotient;
						state_q   <= div_req.start ? S_MOD : S_DONE;
					end
				end
				S_MOD: begin
					if (div_rsp.done) begin
						if (div_rsp.remainder == '0) begin
							report_q <= 1'b1;
							if (toward_kwh_q >= {16'h0000, beats_per_kwh_q}) begin
								toward_kwh_q <= '0;
								kwh_q        <= kwh_q + 32'd1;
							end
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						m_tdata_q  <= {6'd0, average_q, kwh_q, beat_count_q, report_q, beat_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The divider is never restarted while a division is running.
	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

	// A report is only ever flagged together with a counted beat.
	a_report_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] || !m_tdata[1]))
		else $error("report flagged without a beat");

	// The kWh total moves only when leaving the report check.
	a_kwh_from_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(kwh_q != $past(kwh_q)) |-> ($past(state_q) == S_MOD))
		else $error("kWh total changed outside the report check");

	// No request is taken while the divider is still working.
	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_rsp.busy)
		else $error("block idle with divider busy");

endmodule

FILE: test/energy_meter_pulse_counter_checker.sv
`timescale 1ns / 1ps

module energy_meter_pulse_counter_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [emp_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [emp_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [39:0]                   s_tdata,  // line_level[0], now_ms[32:1], zeros
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// beat_counted[0], report_due[1], beat_total[33:2], kwh_total[65:34],
	// average_width_ms[97:66], zeros
	input  logic [103:0]                  m_tdata,
	output int unsigned                   pending_results,
	output int unsigned                   mismatches
);

	typedef struct packed {
		logic [31:0] average_width_ms;
		logic [31:0] kwh_total;
		logic [31:0] beat_total;
		logic        report_due;
		logic        beat_counted;
	} meter_result_t;

	// register copies
	logic [15:0] min_width_ms;
	logic [15:0] report_every;
	logic [15:0] beats_per_unit;
	logic [7:0]  avg_window;

	// meter state
	logic [31:0] pulse_began;
	logic [31:0] width_sum;
	logic [7:0]  width_count;
	logic [31:0] avg_width;
	logic [31:0] beat_total;
	logic [31:0] beats_toward_unit;
	logic [31:0] unit_total;

	meter_result_t awaiting[$];
	int unsigned   failures = 0;

	assign mismatches = failures;

	function automatic meter_result_t meter_edge(input logic level, input logic [31:0] now_ms);
		meter_result_t r;
		logic [31:0]   width;
		logic [8:0]    cnt;
		r = '0;
		if (!level) begin
			pulse_began = now_ms;
		end else if (pulse_began != 32'd0) begin
			width = now_ms - pulse_began;
			cnt = {1'b0, width_count} + 9'd1;
			width_sum = width_sum + width;
			avg_width = width_sum / {23'd0, cnt};
			// clear the window once it overflows, after the average is taken
			if (cnt > {1'b0, avg_window}) begin
				width_sum = 32'd0;
				width_count = 8'd0;
			end else begin
				width_count = cnt[7:0];
			end
			if (width >= {16'd0, min_width_ms}) begin
				r.beat_counted = 1'b1;
				beat_total = beat_total + 32'd1;
				beats_toward_unit = beats_toward_unit + 32'd1;
				if (report_every != 16'd0 && (beat_total % {16'd0, report_every}) == 32'd0) begin
					r.report_due = 1'b1;
					if (beats_toward_unit >= {16'd0, beats_per_unit}) begin
						beats_toward_unit = 32'd0;
						unit_total = unit_total + 32'd1;
					end
				end
			end
		end
		r.beat_total = beat_total;
		r.kwh_total = unit_total;
		r.average_width_ms = avg_width;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
					    input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		meter_result_t got;
		meter_result_t want;
		if (!arst_n) begin
			min_width_ms = emp_pkg::ResetMinPulseMs;
			report_every = emp_pkg::ResetReportInterval;
			beats_per_unit = emp_pkg::ResetBeatsPerKwh;
			avg_window = emp_pkg::ResetAverageWindow;
			pulse_began = 32'd0;
			width_sum = 32'd0;
			width_count = 8'd0;
			avg_width = 32'd0;
			beat_total = 32'd0;
			beats_toward_unit = 32'd0;
			unit_total = 32'd0;
			awaiting.delete();
			pending_results <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					emp_pkg::RegMinPulse:       min_width_ms = cfg_data;
					emp_pkg::RegReportInterval: report_every = cfg_data;
					emp_pkg::RegBeatsPerKwh:    beats_per_unit = cfg_data;
					emp_pkg::RegAverageWindow:  avg_window = cfg_data[7:0];
					default: ;
				endcase
			end
			// take the result first so it can only match an earlier request
			if (m_tvalid && m_tready) begin
				got = m_tdata[97:0];
				if (awaiting.size() == 0) begin
					$display("%0t: unexpected result %0h", $time, got);
					failures++;
				end else begin
					want = awaiting.pop_front();
					check_field("beat_counted", want.beat_counted, got.beat_counted);
					check_field("report_due", want.report_due, got.report_due);
					check_field("beat_total", want.beat_total, got.beat_total);
					check_field("kwh_total", want.kwh_total, got.kwh_total);
					check_field("average_width_ms", want.average_width_ms,
						    got.average_width_ms);
				end
			end
			if (s_tvalid && s_tready)
				awaiting.push_back(meter_edge(s_tdata[0], s_tdata[32:1]));
			pending_results <= awaiting.size();
		end
	end

endmodule

FILE: test/tb_energy_meter_pulse_counter_top.sv
`timescale 1ns / 1ps

module tb_energy_meter_pulse_counter_top;

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [emp_pkg::CfgIndexW-1:0] cfg_index = emp_pkg::RegMinPulse;
	logic [emp_pkg::CfgDataW-1:0]  cfg_data  = '0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [39:0]                   s_tdata   = '0;  // line_level[0], now_ms[32:1], zeros
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	// beat_counted[0], report_due[1], beat_total[33:2], kwh_total[65:34],
	// average_width_ms[97:66], zeros
	logic [103:0]                  m_tdata;

	int unsigned pending_results;
	int unsigned mismatches;

	// timestamp of the most recent low edge sent, so that high edges can aim at
	// chosen pulse widths
	logic [31:0] pulse_low_ms = 32'd0;
	// when set, that side runs back to back for a stretch
	bit steady_sender   = 1'b0;
	bit steady_receiver = 1'b0;
	int unsigned results_taken = 0;

	energy_meter_pulse_counter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	energy_meter_pulse_counter_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.pending_results (pending_results),
		.mismatches      (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one edge request after a random gap and hold it until the block
	// takes it. tvalid is left high so a following request with no gap goes
	// out on the very next cycle.
	task automatic send_edge(input logic level, input logic [31:0] now_ms);
		int unsigned gap;
		gap = steady_sender ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, now_ms, level};
		if (!level)
			pulse_low_ms = now_ms;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Write all four registers on consecutive cycles; only call while idle.
	task automatic load_config(input logic [15:0] min_ms, input logic [15:0] interval,
				   input logic [15:0] per_kwh, input logic [7:0] window);
		cfg_we <= 1'b1;
		cfg_index <= emp_pkg::RegMinPulse;
		cfg_data <= min_ms;
		@(posedge clk);
		cfg_index <= emp_pkg::RegReportInterval;
		cfg_data <= interval;
		@(posedge clk);
		cfg_index <= emp_pkg::RegBeatsPerKwh;
		cfg_data <= per_kwh;
		@(posedge clk);
		cfg_index <= emp_pkg::RegAverageWindow;
		cfg_data <= {8'd0, window};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drop tvalid and hold until every outstanding result has been returned.
	// The extra edge first lets the count pick up the last accepted request.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly well-formed pulses: a low edge followed by one or more high edges
	// whose widths cluster around the beat threshold, with some far-off widths,
	// zero starts and stray high edges at random times mixed in.
	task automatic random_edges(input int unsigned count, input logic [31:0] min_ms);
		int unsigned pick;
		logic [31:0] width;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 32 == 0)
				steady_sender = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_edge(1'b0, ($urandom_range(0, 39) == 0) ? 32'd0 : $urandom());
			end else if (pick < 35) begin
				send_edge(1'b1, $urandom());
			end else begin
				case ($urandom_range(0, 3))
					0: width = min_ms + $urandom_range(0, 2) - 32'd1;
					1: width = $urandom_range(0, 2 * min_ms + 20);
					2: width = $urandom();
					default: width = min_ms + $urandom_range(0, 500);
				endcase
				send_edge(1'b1, pulse_low_ms + width);
			end
		end
	endtask

	// Result side: random stall before each result, occasional back-to-back
	// stretches, and one long hold-off midway so that the block backs up and
	// drops s_tready while requests keep coming.
	initial begin : receiver
		int unsigned stall;
		wait (arst_n === 1'b1);
		forever begin
			if (results_taken % 32 == 0)
				steady_receiver = ($urandom_range(0, 3) == 0);
			if (results_taken == 500)
				stall = 400;
			else
				stall = steady_receiver ? 0 : $urandom_range(0, 18);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			results_taken++;
		end
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed edges under the reset settings.
		// high edge before any start: nothing measured
		send_edge(1'b1, 32'd1234);
		// low edge at time zero leaves no start, so the next high measures nothing
		send_edge(1'b0, 32'd0);
		send_edge(1'b1, 32'd500);
		// width across the timestamp wrap, then a repeated high from the same start
		send_edge(1'b0, 32'hFFFF_FFF0);
		send_edge(1'b1, 32'h0000_0060);
		send_edge(1'b1, 32'h0000_0100);
		// one below the threshold, then exactly on it
		send_edge(1'b0, 32'd1000);
		send_edge(1'b1, 32'd1079);
		send_edge(1'b1, 32'd1080);
		// near-full widths push the running sum round
		send_edge(1'b0, 32'd1);
		send_edge(1'b1, 32'hFFFF_FFFF);
		send_edge(1'b0, 32'hFFFF_FFFF);
		send_edge(1'b1, 32'hFFFF_FFFF);
		send_edge(1'b1, 32'hFFFF_FFFE);
		// alternating bit patterns on the timestamp
		send_edge(1'b0, 32'h5555_5555);
		send_edge(1'b1, 32'hAAAA_AAAA);
		send_edge(1'b1, 32'h0000_0000);
		random_edges(150, {16'd0, emp_pkg::ResetMinPulseMs});
		drain();

		// every width is a beat, every beat reports and rolls a kWh,
		// the average clears after each second measurement
		load_config(16'd0, 16'd1, 16'd1, 8'd1);
		random_edges(150, 32'd0);
		drain();

		// small interval and kWh size so rollovers come often
		load_config(16'd100, 16'd3, 16'd7, 8'd5);
		random_edges(200, 32'd100);
		drain();

		// largest settings: the window runs its count all the way to 256
		load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		random_edges(400, 32'h0000_FFFF);
		drain();

		// short phase with a full pause in the middle
		load_config(16'd1, 16'd4, 16'd2, 8'd16);
		random_edges(50, 32'd1);
		drain();
		random_edges(50, 32'd1);
		drain();

		// allow for any stray result to turn up
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("tb_energy_meter_pulse_counter_top: clean");
		else
			$display("tb_energy_meter_pulse_counter_top: errors");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin : watchdog
		#5_000_000;
		$display("tb_energy_meter_pulse_counter_top: errors");
		$finish;
	end

endmodule
